// ===== hw/rtl/tsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_pkg
// shared types, codes and helpers for the transaction stream deframer
// ----------------------------------------------------------------------------
package tsd_pkg;

    typedef enum logic [1:0] {
        KIND_PACKET  = 2'd0,
        KIND_TRANS   = 2'd1,
        KIND_PAYLOAD = 2'd2
    } t_kind;

    localparam logic [3:0] TYPE_READ    = 4'd0;
    localparam logic [3:0] TYPE_WRITE   = 4'd1;
    localparam logic [3:0] TYPE_NIREAD  = 4'd2;
    localparam logic [3:0] TYPE_NIWRITE = 4'd3;
    localparam logic [3:0] TYPE_RMWBITS = 4'd4;
    localparam logic [3:0] TYPE_RMWSUM  = 4'd5;

    localparam logic [3:0] INFO_SUCCESS = 4'h0;
    localparam logic [3:0] INFO_REQUEST = 4'hF;

    localparam logic [3:0] HDR_VERSION  = 4'h2;
    localparam logic [3:0] HDR_MARK     = 4'hF;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic        swapped;
        logic [11:0] id;
        logic [7:0]  count;
        logic [3:0]  type_code;
        logic [3:0]  info;
        logic [8:0]  plen;
        logic        last;
    } t_result;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage : tsd_pkg
`default_nettype wire

// ===== hw/rtl/tsd_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_decode
// classifies one stream word and computes the next deframer state
// ----------------------------------------------------------------------------
module tsd_decode
    import tsd_pkg::*;
(
    input  wire logic [31:0] i_word,
    input  wire logic        i_swap,
    input  wire logic [8:0]  i_remaining,
    output t_result          o_result,
    output logic             o_swap,
    output logic [8:0]       o_remaining
);

    function automatic logic [8:0] payload_size(
        input logic [7:0] words,
        input logic [3:0] tcode,
        input logic [3:0] info
    );
        logic       resp;
        logic [8:0] size;
        resp = (info == INFO_SUCCESS);
        size = 9'd0;
        if (info == INFO_SUCCESS || info == INFO_REQUEST) begin
            unique case (tcode)
                TYPE_READ, TYPE_NIREAD: begin
                    size = resp ? {1'b0, words} : 9'd1;
                end
                TYPE_WRITE, TYPE_NIWRITE: begin
                    size = resp ? 9'd0 : ({1'b0, words} + 9'd1);
                end
                TYPE_RMWBITS: begin
                    size = resp ? 9'd1 : 9'd3;
                end
                TYPE_RMWSUM: begin
                    size = resp ? 9'd1 : 9'd2;
                end
                default: begin
                    size = 9'd0;
                end
            endcase
        end
        payload_size = size;
    endfunction

    logic [31:0] w_swapped;
    logic [31:0] w_value;
    logic [8:0]  w_plen;
    logic [8:0]  w_dec;

    assign w_swapped = swap32(i_word);
    assign w_value   = i_swap ? w_swapped : i_word;
    assign w_plen    = payload_size(w_value[15:8], w_value[7:4], w_value[3:0]);
    assign w_dec     = i_remaining - 9'd1;

    always_comb begin
        o_result       = '0;
        o_swap         = i_swap;
        o_remaining    = i_remaining;
        priority if (i_remaining != 9'd0) begin
            o_result.kind  = KIND_PAYLOAD;
            o_result.value = w_value;
            o_remaining    = w_dec;
            o_result.last  = (w_dec == 9'd0);
        end else if (i_word[7:4] == HDR_VERSION && i_word[31:28] == HDR_MARK) begin
            o_result.kind  = KIND_PACKET;
            o_result.value = w_swapped;
            o_swap         = 1'b1;
        end else if (i_word[7:4] == HDR_MARK && i_word[31:28] == HDR_VERSION) begin
            o_result.kind  = KIND_PACKET;
            o_result.value = i_word;
            o_swap         = 1'b0;
        end else begin
            o_result.kind      = KIND_TRANS;
            o_result.value     = w_value;
            o_result.id        = w_value[27:16];
            o_result.count     = w_value[15:8];
            o_result.type_code = w_value[7:4];
            o_result.info      = w_value[3:0];
            o_result.plen      = w_plen;
            o_result.last      = (w_plen == 9'd0);
            o_remaining        = w_plen;
        end
        o_result.swapped = o_swap;
    end

endmodule : tsd_decode
`default_nettype wire

// ===== hw/rtl/transaction_stream_deframer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// transaction_stream_deframer_unit
// splits a stream of 32-bit words into packet headers, transaction headers
// and payload words
// ----------------------------------------------------------------------------
// input channel: i_valid / o_ready carry one stream word per transaction.
// output channel: o_valid / i_ready carry one classified word per input
// word, with kind, value after byte swap, byte-order flag, decoded header
// fields, payload length and a last-of-transaction mark.
// the output is registered: an accepted word is shown from the next cycle.
// throughput is one word per cycle while i_ready is high; the decode is a
// single combinational pass from the input port into the output register.
// o_ready is high while the output register is empty or being taken, so a
// stalled receiver holds the current result and blocks only new input.
// reset empties the output register, clears the byte-order flag to native
// order and clears the pending payload count.
// ----------------------------------------------------------------------------
module transaction_stream_deframer_unit
    import tsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_stream_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_word_kind,
    output logic [31:0]      o_word_value,
    output logic             o_swapped_order,
    output logic [11:0]      o_hdr_id,
    output logic [7:0]       o_word_count,
    output logic [3:0]       o_type_code,
    output logic [3:0]       o_hdr_info,
    output logic [8:0]       o_payload_length,
    output logic             o_last_of_transaction
);

    logic       r_valid;
    logic       r_swap;
    logic [8:0] r_remaining;
    t_result    r_out;

    t_result    n_out;
    logic       n_swap;
    logic [8:0] n_remaining;
    logic       w_accept;

    tsd_decode u_decode (
        .i_word      (i_stream_word),
        .i_swap      (r_swap),
        .i_remaining (r_remaining),
        .o_result    (n_out),
        .o_swap      (n_swap),
        .o_remaining (n_remaining)
    );

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_swap      <= 1'b0;
            r_remaining <= 9'd0;
        end else begin
            if (w_accept) begin
                r_valid     <= 1'b1;
                r_swap      <= n_swap;
                r_remaining <= n_remaining;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_valid               = r_valid;
    assign o_word_kind           = r_out.kind;
    assign o_word_value          = r_out.value;
    assign o_swapped_order       = r_out.swapped;
    assign o_hdr_id              = r_out.id;
    assign o_word_count          = r_out.count;
    assign o_type_code           = r_out.type_code;
    assign o_hdr_info            = r_out.info;
    assign o_payload_length      = r_out.plen;
    assign o_last_of_transaction = r_out.last;

endmodule : transaction_stream_deframer_unit
`default_nettype wire
